@@ rtl/rse_pkg.sv @@
// Shared types, constants and helpers for the range shorthand expander.
// Used by rse_ctrl, rse_datapath and range_shorthand_expander_core; no dependencies.
`default_nettype none

package rse_pkg;

    localparam logic [7:0] DASH_CHAR = 8'h2D;

    // character classes
    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_LOWER = 2'd1;
    localparam logic [1:0] CLS_UPPER = 2'd2;
    localparam logic [1:0] CLS_DIGIT = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;       // take a new input character
        logic step;       // advance the run counter
        logic emit_dash;  // output mux selects the dash
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic dec_need_dash;  // item starts with a released dash
        logic dec_has_run;    // item emits a run (one or more characters)
        logic dec_flush;      // item ends with a flushed dash
        logic run_done;       // current run character is the last one
        logic flush_pending;  // registered flush for the item in progress
    } t_dp_stat;

    function automatic logic [1:0] char_class(input logic [7:0] c);
        logic [1:0] cls;
        cls = CLS_NONE;
        if (c >= 8'h61 && c <= 8'h7A) begin
            cls = CLS_LOWER;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            cls = CLS_UPPER;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            cls = CLS_DIGIT;
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rse_datapath.sv @@
// Datapath: range tracking state, run counter and output character mux.
// Depends on rse_pkg.
`default_nettype none

module rse_datapath
    import rse_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    input  wire logic [7:0] i_in_char,
    input  wire logic       i_in_last,
    output t_dp_stat        o_stat,
    output logic [7:0]      o_out_char
);

    logic [7:0] r_prev_char, n_prev_char;
    logic       r_can_start, n_can_start;
    logic       r_dash_held, n_dash_held;
    logic [7:0] r_cur, n_cur;
    logic [7:0] r_end, n_end;
    logic       r_flush, n_flush;

    logic [1:0] cls_prev;
    logic [1:0] cls_x;
    logic       is_range;
    logic       is_hold;

    always_comb begin
        cls_prev = char_class(r_prev_char);
        cls_x    = char_class(i_in_char);
        is_range = r_dash_held && (cls_prev != CLS_NONE) && (cls_prev == cls_x)
                   && (r_prev_char < i_in_char);
        is_hold  = !r_dash_held && (i_in_char == DASH_CHAR) && r_can_start;
    end

    always_comb begin
        n_prev_char = r_prev_char;
        n_can_start = r_can_start;
        n_dash_held = r_dash_held;
        n_cur       = r_cur;
        n_end       = r_end;
        n_flush     = r_flush;
        if (i_cmd.load) begin
            n_end   = i_in_char;
            n_cur   = is_range ? r_prev_char + 8'd1 : i_in_char;
            n_flush = is_hold && i_in_last;
            if (i_in_last) begin
                n_prev_char = '0;
                n_can_start = 1'b0;
                n_dash_held = 1'b0;
            end else if (is_range) begin
                n_can_start = 1'b0;
                n_dash_held = 1'b0;
            end else if (is_hold) begin
                n_dash_held = 1'b1;
            end else begin
                n_prev_char = i_in_char;
                n_can_start = (cls_x != CLS_NONE);
                n_dash_held = 1'b0;
            end
        end else if (i_cmd.step) begin
            n_cur = r_cur + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_char <= '0;
            r_can_start <= 1'b0;
            r_dash_held <= 1'b0;
            r_flush     <= 1'b0;
        end else begin
            r_prev_char <= n_prev_char;
            r_can_start <= n_can_start;
            r_dash_held <= n_dash_held;
            r_flush     <= n_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_end <= n_end;
    end

    always_comb begin
        o_stat.dec_need_dash = r_dash_held && !is_range;
        o_stat.dec_has_run   = !is_hold;
        o_stat.dec_flush     = is_hold && i_in_last;
        o_stat.run_done      = (r_cur == r_end);
        o_stat.flush_pending = r_flush;
        o_out_char           = i_cmd.emit_dash ? DASH_CHAR : r_cur;
    end

endmodule

`default_nettype wire

@@ rtl/rse_ctrl.sv @@
// Controller: sequences leading dash, run characters and flushed dash per item.
// Depends on rse_pkg.
`default_nettype none

module rse_ctrl
    import rse_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output logic          o_run_last,
    output logic          o_string_end,
    input  wire t_dp_stat i_stat,
    input  wire logic     i_last_item,
    output t_dp_cmd       o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DASH  = 2'd1;
    localparam logic [1:0] S_RUN   = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_last, n_last;
    logic       out_xfer;

    assign out_xfer = o_out_valid && !i_out_stall;

    always_comb begin
        n_state        = r_state;
        n_last         = r_last;
        o_cmd          = '0;
        o_in_stall     = 1'b1;
        o_out_valid    = 1'b0;
        o_run_last     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_last     = i_last_item;
                    if (i_stat.dec_need_dash) begin
                        n_state = S_DASH;
                    end else if (i_stat.dec_has_run) begin
                        n_state = S_RUN;
                    end else if (i_stat.dec_flush) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_DASH: begin
                o_out_valid     = 1'b1;
                o_cmd.emit_dash = 1'b1;
                if (out_xfer) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_out_valid = 1'b1;
                o_run_last  = i_stat.run_done && !i_stat.flush_pending;
                if (out_xfer) begin
                    if (i_stat.run_done) begin
                        n_state = i_stat.flush_pending ? S_FLUSH : S_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                o_out_valid     = 1'b1;
                o_cmd.emit_dash = 1'b1;
                o_run_last      = 1'b1;
                if (out_xfer) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_string_end = o_run_last && r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    a_flush_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && out_xfer) |=> (r_state == S_IDLE))
        else $error("flush transfer did not return to idle");

    a_run_after_dash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DASH && out_xfer) |=> (r_state == S_RUN))
        else $error("released dash not followed by a run");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_string_end |-> (o_run_last && o_out_valid))
        else $error("string end without run last");

    a_flush_state_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> i_stat.flush_pending)
        else $error("flush state without a pending flush");

endmodule

`default_nettype wire

@@ rtl/range_shorthand_expander_core.sv @@
// Top level of the range shorthand expander: controller plus datapath.
// Depends on rse_pkg, rse_ctrl and rse_datapath.
`default_nettype none

// Streams 8-bit characters and writes out ranges such as a-d, B-F or 2-7 in
// full (a b c d). A range forms only when both ends are lowercase, both
// uppercase or both digits and the start is below the end; otherwise the dash
// and characters pass unchanged. A dash after a character that can start a
// range is held until the next character decides, and a held dash is flushed
// after an item with i_in_last set. The end of a range cannot start another
// range, so "a-c-e" gives "abc-e". Timing: the block works on one item at a
// time and holds the input stalled until the item is done. An accepted item
// emits its results at one transfer per cycle while the output is not stalled
// (a released dash, the character or range run, a flushed dash); a held dash
// that yields nothing emits no result. The run counter in the datapath steps
// through each run. o_run_last marks the last result of each item and
// o_string_end the last result of a string.
module range_shorthand_expander_core
    import rse_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_char,
    input  wire logic       i_in_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_char,
    output logic            o_run_last,
    output logic            o_string_end
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencing: idle / released dash / run / flushed dash
    rse_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end),
        .i_stat       (dp_stat),
        .i_last_item  (i_in_last),
        .o_cmd        (dp_cmd)
    );

    // range decision, tracking state and the run counter
    rse_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_in_char  (i_in_char),
        .i_in_last  (i_in_last),
        .o_stat     (dp_stat),
        .o_out_char (o_out_char)
    );

endmodule

`default_nettype wire
